// ===== hw/rtl/ibmd_pkg.sv =====
// Shared types and constants for the two-channel bus-master DMA register block.
package ibmd_pkg;

  localparam int unsigned BufferBytes = 131072;
  localparam int unsigned OffW = 18;
  localparam int unsigned SizeW = 17;

  localparam logic [2:0] CmdRead = 3'd0;
  localparam logic [2:0] CmdWrite = 3'd1;
  localparam logic [2:0] CmdDataReady = 3'd2;
  localparam logic [2:0] CmdSetIrq = 3'd3;
  localparam logic [2:0] CmdTick = 3'd4;

  localparam logic [2:0] RegCommand = 3'd0;
  localparam logic [2:0] RegStatus = 3'd2;
  localparam logic [2:0] RegTableBase = 3'd4;

  localparam int unsigned CmdStartBit = 0;
  localparam int unsigned CmdWriteBit = 3;
  localparam int unsigned StActiveBit = 0;
  localparam int unsigned StIrqBit = 2;
  localparam int unsigned EotBit = 31;

  localparam logic [7:0] StatusKeepMask = 8'h60;
  localparam logic [7:0] StatusClearMask = 8'h06;
  localparam logic [31:0] BaseAlignMask = 32'hffff_fffc;
  localparam logic [15:0] SizeMask = 16'hfffe;
  localparam logic [SizeW-1:0] SizeMax = 17'h10000;
  localparam logic [31:0] PtrStep = 32'd8;
  localparam logic [31:0] Unmapped = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0] cmd;
    logic channel;
    logic [3:0] reg_address;
    logic [31:0] wr_data;
    logic [31:0] prd_count_word;
    logic xfer_error;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic tick_served;
    logic served_channel;
    logic [31:0] prd_pointer;
    logic [SizeW-1:0] xfer_bytes;
    logic [OffW-1:0] buffer_offset;
    logic end_of_table;
    logic complete_notify;
  } rsp_t;

endpackage

// ===== hw/rtl/ibmd_core.sv =====
// Per-channel register state, register access decode and tick service logic.
module ibmd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ibmd_pkg::req_t req_i,
  output ibmd_pkg::rsp_t rsp_o
);

  logic [7:0] cmd_q [2];
  logic [7:0] cmd_d [2];
  logic [7:0] st_q [2];
  logic [7:0] st_d [2];
  logic [31:0] base_q [2];
  logic [31:0] base_d [2];
  logic [31:0] ptr_q [2];
  logic [31:0] ptr_d [2];
  logic [ibmd_pkg::OffW-1:0] off_q [2];
  logic [ibmd_pkg::OffW-1:0] off_d [2];
  logic [1:0] rdy_q;
  logic [1:0] rdy_d;

  logic hit0, hit1, found, tick_ch, sel_ch, blocked, served, is_tick, eot;
  logic [2:0] roff;
  logic [7:0] cur_cmd, cur_st;
  logic [31:0] cur_base, cur_ptr;
  logic [ibmd_pkg::OffW-1:0] cur_off, wrap_off, next_off;
  logic [ibmd_pkg::SizeW-1:0] size;
  logic [ibmd_pkg::OffW:0] end_sum;
  logic start_now, start_was;

  assign roff = req_i.reg_address[2:0];
  assign is_tick = (req_i.cmd == ibmd_pkg::CmdTick);

  assign hit0 = st_q[0][ibmd_pkg::StActiveBit] && (ptr_q[0] != '0);
  assign hit1 = st_q[1][ibmd_pkg::StActiveBit] && (ptr_q[1] != '0);
  assign found = hit0 | hit1;
  assign tick_ch = ~hit0;

  always_comb begin
    case (req_i.cmd)
      ibmd_pkg::CmdRead, ibmd_pkg::CmdWrite: sel_ch = req_i.reg_address[3];
      ibmd_pkg::CmdTick: sel_ch = tick_ch;
      default: sel_ch = req_i.channel;
    endcase
  end

  assign cur_cmd = cmd_q[sel_ch];
  assign cur_st = st_q[sel_ch];
  assign cur_base = base_q[sel_ch];
  assign cur_ptr = ptr_q[sel_ch];
  assign cur_off = off_q[sel_ch];

  assign blocked = ~rdy_q[sel_ch] & cur_cmd[ibmd_pkg::CmdWriteBit];
  assign served = is_tick & found & ~blocked;
  assign eot = req_i.prd_count_word[ibmd_pkg::EotBit];

  assign size = (req_i.prd_count_word[15:0] & ibmd_pkg::SizeMask) == '0 ?
                ibmd_pkg::SizeMax :
                {1'b0, req_i.prd_count_word[15:0] & ibmd_pkg::SizeMask};
  assign end_sum = {1'b0, cur_off} + {2'b00, size};
  assign wrap_off = (end_sum > (ibmd_pkg::OffW+1)'(ibmd_pkg::BufferBytes)) ? '0 : cur_off;
  assign next_off = wrap_off + {1'b0, size};

  assign start_now = req_i.wr_data[ibmd_pkg::CmdStartBit];
  assign start_was = cur_cmd[ibmd_pkg::CmdStartBit];

  always_comb begin
    cmd_d = cmd_q;
    st_d = st_q;
    base_d = base_q;
    ptr_d = ptr_q;
    off_d = off_q;
    rdy_d = rdy_q;
    rsp_o = '0;
    case (req_i.cmd)
      ibmd_pkg::CmdRead: begin
        case (roff)
          ibmd_pkg::RegCommand: rsp_o.read_data = {24'd0, cur_cmd};
          ibmd_pkg::RegStatus: rsp_o.read_data = {24'd0, cur_st};
          ibmd_pkg::RegTableBase: rsp_o.read_data = cur_base;
          default: rsp_o.read_data = ibmd_pkg::Unmapped;
        endcase
      end
      ibmd_pkg::CmdWrite: begin
        case (roff)
          ibmd_pkg::RegCommand: begin
            if (start_now && !start_was) begin
              cmd_d[sel_ch] = req_i.wr_data[7:0];
              st_d[sel_ch][ibmd_pkg::StActiveBit] = 1'b1;
              ptr_d[sel_ch] = cur_base;
              off_d[sel_ch] = '0;
            end else if (!start_now && start_was) begin
              cmd_d[sel_ch] = req_i.wr_data[7:0];
              st_d[sel_ch][ibmd_pkg::StActiveBit] = 1'b0;
            end
          end
          ibmd_pkg::RegStatus: begin
            st_d[sel_ch] = (req_i.wr_data[7:0] & ibmd_pkg::StatusKeepMask)
                         | (cur_st & 8'(1 << ibmd_pkg::StActiveBit))
                         | (cur_st & ~req_i.wr_data[7:0] & ibmd_pkg::StatusClearMask);
          end
          ibmd_pkg::RegTableBase: base_d[sel_ch] = req_i.wr_data & ibmd_pkg::BaseAlignMask;
          default: ;
        endcase
      end
      ibmd_pkg::CmdDataReady: rdy_d[sel_ch] = 1'b1;
      ibmd_pkg::CmdSetIrq: st_d[sel_ch][ibmd_pkg::StIrqBit] = 1'b1;
      ibmd_pkg::CmdTick: begin
        if (served) begin
          rsp_o.tick_served = 1'b1;
          rsp_o.served_channel = sel_ch;
          rsp_o.prd_pointer = cur_ptr;
          rsp_o.xfer_bytes = size;
          rsp_o.buffer_offset = wrap_off;
          rsp_o.end_of_table = eot;
          off_d[sel_ch] = wrap_off;
          if (req_i.xfer_error) begin
            rsp_o.complete_notify = 1'b1;
          end else if (eot) begin
            st_d[sel_ch][ibmd_pkg::StActiveBit] = 1'b0;
            st_d[sel_ch][ibmd_pkg::StIrqBit] = 1'b1;
            ptr_d[sel_ch] = '0;
            off_d[sel_ch] = '0;
            rsp_o.complete_notify = 1'b1;
          end else begin
            off_d[sel_ch] = next_off;
            ptr_d[sel_ch] = cur_ptr + ibmd_pkg::PtrStep;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '{default: '0};
      st_q <= '{default: '0};
      base_q <= '{default: '0};
      ptr_q <= '{default: '0};
      off_q <= '{default: '0};
      rdy_q <= '0;
    end else if (en_i) begin
      cmd_q <= cmd_d;
      st_q <= st_d;
      base_q <= base_d;
      ptr_q <= ptr_d;
      off_q <= off_d;
      rdy_q <= rdy_d;
    end
  end

  // A served channel must have been active with a live pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && served |-> cur_st[ibmd_pkg::StActiveBit] && (cur_ptr != '0))
    else $error("served channel was not active with a nonzero pointer");

  // End of table without error stops the channel and clears its pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && served && eot && !req_i.xfer_error |=>
      !st_q[$past(sel_ch)][ibmd_pkg::StActiveBit] && (ptr_q[$past(sel_ch)] == '0))
    else $error("end of table did not finish the channel");

  // A normal entry advances the pointer by one descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && served && !eot && !req_i.xfer_error |=>
      ptr_q[$past(sel_ch)] == $past(cur_ptr) + ibmd_pkg::PtrStep)
    else $error("pointer did not advance by one descriptor");

  // The buffer offset never runs past the end of the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_q[0] <= ibmd_pkg::OffW'(ibmd_pkg::BufferBytes)) &&
    (off_q[1] <= ibmd_pkg::OffW'(ibmd_pkg::BufferBytes)))
    else $error("buffer offset beyond buffer size");

endmodule

// ===== hw/rtl/ide_bus_master_dma_regs.sv =====
// Top level of the two-channel bus-master DMA register block with request and result registers.
// Every request produces exactly one result, which passes through the request register and then the result register.
// One request is taken per cycle; a stalled result holds the request register.
// Register state updates when a request moves from the request to the result register.
// Reset clears all channel registers, the data-ready flags and both valid flags.
module ide_bus_master_dma_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  ibmd_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output ibmd_pkg::rsp_t rsp_o
);

  logic in_vld_q, out_vld_q, adv, accept, step;
  ibmd_pkg::req_t in_q;
  ibmd_pkg::rsp_t out_q, core_rsp;

  assign adv = ~out_vld_q | ~rsp_stall_i;
  assign req_stall_o = in_vld_q & ~adv;
  assign accept = req_valid_i & ~req_stall_o;
  assign step = in_vld_q & adv;

  ibmd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .req_i  (in_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i;
    end
    if (step) begin
      out_q <= core_rsp;
    end
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o = out_q;

  // A request is only held back while an earlier one waits behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> in_vld_q && out_vld_q && rsp_stall_i)
    else $error("request stalled without a blocked result");

  // A request in the request register reaches the result register once the output frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> rsp_valid_o)
    else $error("processed request produced no result");

  // Results only show a served tick when they came from a tick request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && core_rsp.tick_served |-> in_q.cmd == ibmd_pkg::CmdTick)
    else $error("tick result from a non-tick request");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the two-channel bus-master DMA register block.
module tb;
  import ibmd_pkg::*;

  localparam int unsigned RandomItems = 1600;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit = 900000;

  class dma_tracker;
    logic [7:0] command_q[2];
    logic [7:0] status_q[2];
    logic [31:0] base_q[2];
    logic [31:0] pointer_q[2];
    logic [OffW-1:0] offset_q[2];
    bit ready_q[2];
    rsp_t awaited_rsp[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < 2; i++) begin
        command_q[i] = '0;
        status_q[i] = '0;
        base_q[i] = '0;
        pointer_q[i] = '0;
        offset_q[i] = '0;
        ready_q[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function int pending();
      return awaited_rsp.size();
    endfunction

    function logic [31:0] read_reg(int ch, logic [2:0] off);
      case (off)
        RegCommand: return {24'b0, command_q[ch]};
        RegStatus: return {24'b0, status_q[ch]};
        RegTableBase: return base_q[ch];
        default: return Unmapped;
      endcase
    endfunction

    function void write_reg(int ch, logic [2:0] off, logic [31:0] v);
      case (off)
        RegCommand: begin
          if (v[CmdStartBit] && !command_q[ch][CmdStartBit]) begin
            command_q[ch] = v[7:0];
            status_q[ch][StActiveBit] = 1'b1;
            pointer_q[ch] = base_q[ch];
            offset_q[ch] = '0;
          end else if (!v[CmdStartBit] && command_q[ch][CmdStartBit]) begin
            command_q[ch] = v[7:0];
            status_q[ch][StActiveBit] = 1'b0;
          end
        end
        RegStatus: begin
          status_q[ch] = (v[7:0] & StatusKeepMask) | (status_q[ch] & 8'h01)
                         | (status_q[ch] & ~v[7:0] & StatusClearMask);
        end
        RegTableBase: base_q[ch] = v & BaseAlignMask;
        default: ;
      endcase
    endfunction

    function rsp_t serve_tick(logic [31:0] count, logic err);
      rsp_t e;
      int sel;
      logic [SizeW-1:0] bytes;
      logic [31:0] start;
      e = '0;
      sel = -1;
      for (int i = 0; i < 2; i++) begin
        if (sel < 0 && status_q[i][StActiveBit] && pointer_q[i] != 0) sel = i;
      end
      if (sel < 0) return e;
      if (!ready_q[sel] && command_q[sel][CmdWriteBit]) return e;
      bytes = {1'b0, count[15:0] & SizeMask};
      if (bytes == 0) bytes = SizeMax;
      start = 32'(offset_q[sel]);
      if (start + 32'(bytes) > BufferBytes) start = '0;
      offset_q[sel] = start[OffW-1:0];
      e.tick_served = 1'b1;
      e.served_channel = sel[0];
      e.prd_pointer = pointer_q[sel];
      e.xfer_bytes = bytes;
      e.buffer_offset = start[OffW-1:0];
      e.end_of_table = count[EotBit];
      if (err) begin
        e.complete_notify = 1'b1;
        return e;
      end
      if (count[EotBit]) begin
        status_q[sel][StActiveBit] = 1'b0;
        status_q[sel][StIrqBit] = 1'b1;
        pointer_q[sel] = '0;
        offset_q[sel] = '0;
        e.complete_notify = 1'b1;
      end else begin
        offset_q[sel] = start[OffW-1:0] + OffW'(bytes);
        pointer_q[sel] = pointer_q[sel] + PtrStep;
      end
      return e;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int ch;
      e = '0;
      ch = int'(r.reg_address[3]);
      case (r.cmd)
        CmdRead: e.read_data = read_reg(ch, r.reg_address[2:0]);
        CmdWrite: write_reg(ch, r.reg_address[2:0], r.wr_data);
        CmdDataReady: ready_q[r.channel] = 1'b1;
        CmdSetIrq: status_q[r.channel][StIrqBit] = 1'b1;
        CmdTick: e = serve_tick(r.prd_count_word, r.xfer_error);
        default: ;
      endcase
      awaited_rsp.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (awaited_rsp.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, got);
        return;
      end
      e = awaited_rsp.pop_front();
      compare_field("read_data", e.read_data, got.read_data);
      compare_field("tick_served", 32'(e.tick_served), 32'(got.tick_served));
      compare_field("served_channel", 32'(e.served_channel), 32'(got.served_channel));
      compare_field("prd_pointer", e.prd_pointer, got.prd_pointer);
      compare_field("xfer_bytes", 32'(e.xfer_bytes), 32'(got.xfer_bytes));
      compare_field("buffer_offset", 32'(e.buffer_offset), 32'(got.buffer_offset));
      compare_field("end_of_table", 32'(e.end_of_table), 32'(got.end_of_table));
      compare_field("complete_notify", 32'(e.complete_notify), 32'(got.complete_notify));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  req_t req_i;
  logic rsp_valid_o;
  logic rsp_stall_i;
  rsp_t rsp_o;

  dma_tracker sb = new();
  int unsigned sent;
  int unsigned cycles;
  bit quiet;
  bit hold_off;

  ide_bus_master_dma_regs DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i(req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o(rsp_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ide_bus_master_dma_regs verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) sb.check_result(rsp_o);
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t mk(logic [2:0] cmd, logic ch, logic [3:0] addr,
                              logic [31:0] wd, logic [31:0] cw, logic err);
    req_t r;
    r.cmd = cmd;
    r.channel = ch;
    r.reg_address = addr;
    r.wr_data = wd;
    r.prd_count_word = cw;
    r.xfer_error = err;
    return r;
  endfunction

  function automatic req_t rand_misc();
    req_t r;
    r = mk($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 1) == 0) r.cmd = CmdRead;
    return r;
  endfunction

  // Receiver side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int n;
    rsp_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        rsp_stall_i <= 1'b1;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
        hold_off = 1'b0;
        rsp_stall_i <= 1'b0;
      end else begin
        n = gap_len();
        if (n == 0) begin
          rsp_stall_i <= 1'b0;
        end else begin
          rsp_stall_i <= 1'b1;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send(req_t r);
    int n;
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    sb.note_request(r);
    sent++;
    n = gap_len();
    if (n > 0) begin
      req_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send(mk(CmdRead, 0, 4'h0, 0, 0, 0));
    send(mk(CmdRead, 1, 4'h2, 0, 0, 0));
    send(mk(CmdRead, 0, 4'h4, 0, 0, 0));
    send(mk(CmdRead, 1, 4'hf, '1, '1, 1));
    send(mk(CmdTick, 0, 4'h0, 0, '1, 0));
    send(mk(CmdWrite, 0, {1'b0, RegTableBase}, 32'hffff_ffff, 0, 0));
    send(mk(CmdWrite, 0, {1'b0, RegCommand}, 32'h0000_0009, 0, 0));
    send(mk(CmdTick, 0, 4'h0, 0, 32'h0000_0100, 0));
    send(mk(CmdDataReady, 0, 4'h0, 0, 0, 0));
    send(mk(CmdTick, 0, 4'h0, 0, 32'h0000_0000, 0));
    send(mk(CmdTick, 0, 4'h0, 0, 32'h0000_ffff, 0));
    send(mk(CmdTick, 0, 4'h0, 0, 32'h0000_0002, 1));
    send(mk(CmdTick, 0, 4'h0, 0, 32'h0000_0004, 0));
    send(mk(CmdWrite, 0, {1'b0, RegCommand}, 32'hffff_ffff, 0, 0));
    send(mk(CmdSetIrq, 1, 4'h0, 0, 0, 0));
    send(mk(CmdWrite, 0, {1'b0, RegStatus}, 32'h0000_00ff, 0, 0));
    send(mk(CmdTick, 0, 4'h0, 0, 32'h8000_0010, 0));
    send(mk(CmdRead, 0, {1'b0, RegStatus}, 0, 0, 0));
    send(mk(CmdWrite, 0, {1'b0, RegCommand}, 32'h0000_0000, 0, 0));
    send(mk(CmdWrite, 1, {1'b1, RegTableBase}, 32'hffff_fff8, 0, 0));
    send(mk(CmdWrite, 1, {1'b1, RegCommand}, 32'h0000_0001, 0, 0));
    send(mk(CmdTick, 1, 4'h0, 0, 32'hffff_ffff, 1));
    send(mk(CmdTick, 1, 4'h0, 0, 32'h0000_0200, 0));
    send(mk(CmdTick, 1, 4'h0, 0, 32'h0000_0200, 0));
    send(mk(CmdWrite, 1, 4'hb, '1, 0, 0));
    send(mk(3'd5, 1, 4'hf, '1, '1, 1));
    send(mk(3'd7, 0, 4'h0, 0, 0, 0));
  endtask

  // A well-formed channel program: base, stop, maybe ready, start, ticks.
  task automatic run_sequence();
    int ch;
    int n;
    logic [31:0] v;
    logic [31:0] cw;
    ch = $urandom_range(0, 1);
    v = $urandom;
    if ($urandom_range(0, 15) == 0) v[31:2] = '0;
    send(mk(CmdWrite, $urandom, {ch[0], RegTableBase}, v, $urandom, $urandom));
    v = $urandom;
    v[CmdStartBit] = 1'b0;
    send(mk(CmdWrite, $urandom, {ch[0], RegCommand}, v, $urandom, $urandom));
    if ($urandom_range(0, 1) == 0) begin
      send(mk(CmdDataReady, ch[0], $urandom, $urandom, $urandom, $urandom));
    end
    v = $urandom;
    v[CmdStartBit] = 1'b1;
    send(mk(CmdWrite, $urandom, {ch[0], RegCommand}, v, $urandom, $urandom));
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      cw = $urandom;
      if ($urandom_range(0, 7) == 0) cw[15:1] = '0;
      cw[EotBit] = (k == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
      send(mk(CmdTick, $urandom, $urandom, $urandom, cw, $urandom_range(0, 9) == 0));
      if ($urandom_range(0, 5) == 0) send(rand_misc());
    end
  endtask

  initial begin
    int phase;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    sent = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    phase = 0;
    while (sent < RandomItems) begin
      quiet = (phase % 4 == 3);
      if (phase == 2) hold_off = 1'b1;
      if (phase == 5) drain();
      repeat (8) begin
        if ($urandom_range(0, 4) == 0) send(rand_misc());
        else run_sequence();
      end
      phase++;
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ide_bus_master_dma_regs verification clean");
    end else begin
      $display("ide_bus_master_dma_regs verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ibmd_pkg.sv
hw/rtl/ibmd_core.sv
hw/rtl/ide_bus_master_dma_regs.sv
tb/sv/tb.sv
